// ----- hw/rtl/rlpk_pkg.sv -----
// Shared types, codes and constants for the radio link pairing and keepalive block.
package rlpk_pkg;

  localparam int ATTEMPT_W = 4;
  localparam int IDLE_W = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 64;

  localparam int RESPOND_ATTEMPTS_DEF = 5;
  localparam int CONFIRM_LIMIT_DEF = 10;
  localparam logic [IDLE_W-1:0] ABANDON_TICKS_RST = 16'd10;

  // command codes
  localparam logic [1:0] CMD_MSG  = 2'd0;
  localparam logic [1:0] CMD_TICK = 2'd1;
  localparam logic [1:0] CMD_SLOT = 2'd2;

  // send kinds
  localparam logic [1:0] SEND_NONE      = 2'd0;
  localparam logic [1:0] SEND_RECOGNIZE = 2'd1;
  localparam logic [1:0] SEND_PAYLOAD   = 2'd2;

  // drop causes
  localparam logic [2:0] CAUSE_NONE       = 3'd0;
  localparam logic [2:0] CAUSE_TIMEOUT    = 3'd1;
  localparam logic [2:0] CAUSE_COMPETING  = 3'd2;
  localparam logic [2:0] CAUSE_DISCONNECT = 3'd3;
  localparam logic [2:0] CAUSE_HEARTBEAT  = 3'd4;

  // reported link states
  localparam logic [2:0] LS_LISTEN    = 3'd0;
  localparam logic [2:0] LS_RESPOND   = 3'd1;
  localparam logic [2:0] LS_CONFIRM   = 3'd2;
  localparam logic [2:0] LS_CONNECTED = 3'd3;
  localparam logic [2:0] LS_OTHER     = 3'd4;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_OWN_ID        = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BEACON_ID     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CONFIRM_ID    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_RECOGNIZE_ID  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_DISCONNECT_ID = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_KEEPALIVE     = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_ABANDON       = 3'd6;

  typedef enum logic [4:0] {
    PH_LISTEN    = 5'b00001,
    PH_RESPOND   = 5'b00010,
    PH_CONFIRM   = 5'b00100,
    PH_CONNECTED = 5'b01000,
    PH_OTHER     = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] msg_id;
    logic [7:0] msg_byte1;
    logic [7:0] msg_byte2;
    logic       reply_wanted;
  } in_t;

  typedef struct packed {
    logic [2:0] link_state;
    logic       send_request;
    logic [1:0] send_kind;
    logic [7:0] tx_byte0;
    logic [7:0] tx_byte1;
    logic [7:0] tx_byte2;
    logic       expect_reply;
    logic       led_on;
    logic [2:0] drop_cause;
  } out_t;

  typedef struct packed {
    logic [7:0]        own_id;
    logic [7:0]        beacon_msg_id;
    logic [7:0]        confirm_msg_id;
    logic [7:0]        recognize_msg_id;
    logic [7:0]        disconnect_msg_id;
    logic [63:0]       keepalive_mask;
    logic [IDLE_W-1:0] abandon_ticks;
  } cfg_t;

  function automatic logic [2:0] phase_code(phase_t ph);
    logic [2:0] code;
    case (ph)
      PH_LISTEN:    code = LS_LISTEN;
      PH_RESPOND:   code = LS_RESPOND;
      PH_CONFIRM:   code = LS_CONFIRM;
      PH_CONNECTED: code = LS_CONNECTED;
      PH_OTHER:     code = LS_OTHER;
      default:      code = LS_LISTEN;
    endcase
    return code;
  endfunction

endpackage

// ----- hw/rtl/rlpk_cfg.sv -----
// Configuration register file for the link pairing block.
module rlpk_cfg
  import rlpk_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr_en,
  input  logic [CFG_INDEX_W-1:0] wr_index,
  input  logic [CFG_DATA_W-1:0]  wr_data,
  output cfg_t                   cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.own_id            <= '0;
      cfg.beacon_msg_id     <= '0;
      cfg.confirm_msg_id    <= '0;
      cfg.recognize_msg_id  <= '0;
      cfg.disconnect_msg_id <= '0;
      cfg.keepalive_mask    <= '0;
      cfg.abandon_ticks     <= ABANDON_TICKS_RST;
    end else if (wr_en) begin
      case (wr_index)
        REG_OWN_ID:        cfg.own_id            <= wr_data[7:0];
        REG_BEACON_ID:     cfg.beacon_msg_id     <= wr_data[7:0];
        REG_CONFIRM_ID:    cfg.confirm_msg_id    <= wr_data[7:0];
        REG_RECOGNIZE_ID:  cfg.recognize_msg_id  <= wr_data[7:0];
        REG_DISCONNECT_ID: cfg.disconnect_msg_id <= wr_data[7:0];
        REG_KEEPALIVE:     cfg.keepalive_mask    <= wr_data;
        REG_ABANDON:       cfg.abandon_ticks     <= wr_data[IDLE_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- hw/rtl/rlpk_core.sv -----
// Link phase state and the per-item next-state and result logic.
module rlpk_core
  import rlpk_pkg::*;
#(
  parameter int RESPOND_ATTEMPTS = RESPOND_ATTEMPTS_DEF,
  parameter int CONFIRM_LIMIT    = CONFIRM_LIMIT_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic advance,
  input  in_t  item,
  input  cfg_t cfg,
  output out_t res
);

  phase_t                 phase, phase_next;
  logic [7:0]             paired_tx, paired_tx_next;
  logic [ATTEMPT_W-1:0]   attempt, attempt_next, attempt_inc;
  logic [IDLE_W-1:0]      idle, idle_next, idle_inc;
  logic                   led, led_next;
  logic                   keepalive_hit;

  assign attempt_inc = attempt + 1'b1;
  assign idle_inc = (idle == {IDLE_W{1'b1}}) ? idle : idle + 1'b1;
  // ids of 64 and above never count as keepalive
  assign keepalive_hit = (item.msg_id[7:6] == 2'b00) && cfg.keepalive_mask[item.msg_id[5:0]];

  always_comb begin
    phase_next     = phase;
    paired_tx_next = paired_tx;
    attempt_next   = attempt;
    idle_next      = idle;
    led_next       = led;
    res            = '0;
    case (item.cmd)
      CMD_MSG: begin
        case (phase)
          PH_LISTEN: begin
            if (item.msg_id == cfg.beacon_msg_id) begin
              paired_tx_next = item.msg_byte1;
              phase_next     = PH_RESPOND;
              attempt_next   = '0;
              led_next       = 1'b1;
            end
          end
          PH_CONFIRM: begin
            if (item.msg_id == cfg.confirm_msg_id) begin
              if (item.msg_byte2 == cfg.own_id && item.msg_byte1 == paired_tx) begin
                phase_next = PH_CONNECTED;
                led_next   = 1'b1;
                idle_next  = '0;
              end else begin
                phase_next     = PH_OTHER;
                led_next       = 1'b0;
                res.drop_cause = CAUSE_COMPETING;
              end
            end
          end
          PH_CONNECTED: begin
            if (item.msg_id == cfg.disconnect_msg_id) begin
              phase_next     = PH_LISTEN;
              res.drop_cause = CAUSE_DISCONNECT;
            end else begin
              res.send_request = item.reply_wanted;
              if (keepalive_hit) idle_next = '0;
            end
          end
          default: ;
        endcase
      end
      CMD_TICK: begin
        case (phase)
          PH_RESPOND: begin
            led_next     = attempt[0];
            attempt_next = attempt_inc;
            if (attempt_inc == ATTEMPT_W'(RESPOND_ATTEMPTS)) phase_next = PH_CONFIRM;
            else res.send_request = 1'b1;
          end
          PH_CONFIRM: begin
            attempt_next = attempt_inc;
            if (attempt_inc == ATTEMPT_W'(CONFIRM_LIMIT)) begin
              phase_next     = PH_LISTEN;
              led_next       = 1'b0;
              res.drop_cause = CAUSE_TIMEOUT;
            end
          end
          PH_CONNECTED: begin
            idle_next = idle_inc;
            if (idle_inc > cfg.abandon_ticks) begin
              phase_next     = PH_LISTEN;
              res.drop_cause = CAUSE_HEARTBEAT;
            end
          end
          default: ;
        endcase
      end
      CMD_SLOT: begin
        case (phase)
          PH_RESPOND: begin
            res.send_kind    = SEND_RECOGNIZE;
            res.tx_byte0     = cfg.recognize_msg_id;
            res.tx_byte1     = cfg.own_id;
            res.tx_byte2     = paired_tx;
            res.expect_reply = 1'b1;
          end
          PH_CONNECTED: begin
            led_next         = ~led;
            res.send_kind    = SEND_PAYLOAD;
            res.expect_reply = 1'b1;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    res.link_state = phase_code(phase_next);
    res.led_on     = led_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_LISTEN;
      paired_tx <= '0;
      attempt   <= '0;
      idle      <= '0;
      led       <= 1'b0;
    end else if (advance) begin
      phase     <= phase_next;
      paired_tx <= paired_tx_next;
      attempt   <= attempt_next;
      idle      <= idle_next;
      led       <= led_next;
    end
  end

endmodule

// ----- hw/rtl/radio_link_pairing_keepalive.sv -----
// An accepted item is held in the input stage; its result is registered into the
// result register when that register is empty or being taken, and is held there until taken.
// Throughput: one item per cycle while the output is not stalled; the state update is a
// combinational step between the input stage and the result register.
// Reset (rst, synchronous): link listening, counters and LED cleared,
// registers to their reset values; both pipeline stages empty.
module radio_link_pairing_keepalive
  import rlpk_pkg::*;
#(
  parameter int RESPOND_ATTEMPTS = RESPOND_ATTEMPTS_DEF,
  parameter int CONFIRM_LIMIT    = CONFIRM_LIMIT_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  in_t                    in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_t                   out_data,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t cfg;
  in_t  in_reg;
  logic in_full;
  logic advance;
  out_t res;

  assign cfg_ready = 1'b1;
  assign advance   = in_full && (!out_valid || !out_stall);
  assign in_stall  = in_full && !advance;

  rlpk_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  rlpk_core #(
    .RESPOND_ATTEMPTS (RESPOND_ATTEMPTS),
    .CONFIRM_LIMIT    (CONFIRM_LIMIT)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (in_reg),
    .cfg     (cfg),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      in_full   <= (in_valid && !in_stall) || in_stall;
      out_valid <= advance || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) in_reg <= in_data;
    if (advance) out_data <= res;
  end

  // a drop always lands in listening or the terminal phase
  a_drop_phase: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.drop_cause != CAUSE_NONE |->
      (out_data.link_state == LS_LISTEN || out_data.link_state == LS_OTHER))
    else $error("drop reported outside listening/other");

  // any frame sent expects a reply
  a_frame_reply: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.send_kind != SEND_NONE |-> out_data.expect_reply)
    else $error("frame without expect_reply");

  // an item held in the input stage is not lost while the output stalls
  a_hold: assert property (@(posedge clk) disable iff (rst)
    in_full && !advance |=> in_full && $stable(in_reg))
    else $error("input stage lost an item");

  // a result moves on only when the input stage fed it
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    !out_valid && !in_full |=> !out_valid)
    else $error("result appeared with no item");

endmodule

// ----- tb/radio_link_pairing_keepalive_tb.sv -----
// Self-checking testbench for the radio link pairing and keepalive block.
`timescale 1ns / 1ps

module radio_link_pairing_keepalive_tb;
  import rlpk_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int items_sent = 0;

  radio_link_pairing_keepalive dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Tracks the link machine and holds the reports it still owes.
  class link_tracker;
    phase_t phase = PH_LISTEN;
    logic [7:0] paired = '0;
    logic [ATTEMPT_W-1:0] attempts = '0;
    logic [IDLE_W-1:0] idle = '0;
    logic led = 1'b0;
    logic [7:0] rx_id = '0;
    logic [7:0] beacon_id = '0;
    logic [7:0] confirm_id = '0;
    logic [7:0] recog_id = '0;
    logic [7:0] disc_id = '0;
    logic [63:0] ka_mask = '0;
    logic [IDLE_W-1:0] abandon = ABANDON_TICKS_RST;
    out_t reports_due[$];
    int bad_reports = 0;

    function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_OWN_ID:        rx_id = val[7:0];
        REG_BEACON_ID:     beacon_id = val[7:0];
        REG_CONFIRM_ID:    confirm_id = val[7:0];
        REG_RECOGNIZE_ID:  recog_id = val[7:0];
        REG_DISCONNECT_ID: disc_id = val[7:0];
        REG_KEEPALIVE:     ka_mask = val;
        REG_ABANDON:       abandon = val[IDLE_W-1:0];
        default: ;
      endcase
    endfunction

    function void take_event(in_t ev);
      out_t r;
      r = '0;
      case (ev.cmd)
        CMD_MSG: begin
          case (phase)
            PH_LISTEN: if (ev.msg_id == beacon_id) begin
              paired = ev.msg_byte1;
              phase = PH_RESPOND;
              attempts = '0;
              led = 1'b1;
            end
            PH_CONFIRM: if (ev.msg_id == confirm_id) begin
              if (ev.msg_byte2 == rx_id && ev.msg_byte1 == paired) begin
                phase = PH_CONNECTED;
                led = 1'b1;
                idle = '0;
              end else begin
                phase = PH_OTHER;
                led = 1'b0;
                r.drop_cause = CAUSE_COMPETING;
              end
            end
            PH_CONNECTED: begin
              // disconnect wins over keepalive
              if (ev.msg_id == disc_id) begin
                phase = PH_LISTEN;
                r.drop_cause = CAUSE_DISCONNECT;
              end else begin
                r.send_request = ev.reply_wanted;
                if (ev.msg_id < 8'd64 && ka_mask[ev.msg_id[5:0]]) idle = '0;
              end
            end
            default: ;
          endcase
        end
        CMD_TICK: begin
          case (phase)
            PH_RESPOND: begin
              led = attempts[0];
              attempts = attempts + 1'b1;
              if (attempts == ATTEMPT_W'(RESPOND_ATTEMPTS_DEF)) phase = PH_CONFIRM;
              else r.send_request = 1'b1;
            end
            PH_CONFIRM: begin
              attempts = attempts + 1'b1;
              if (attempts == ATTEMPT_W'(CONFIRM_LIMIT_DEF)) begin
                phase = PH_LISTEN;
                led = 1'b0;
                r.drop_cause = CAUSE_TIMEOUT;
              end
            end
            PH_CONNECTED: begin
              if (idle != '1) idle = idle + 1'b1;
              if (idle > abandon) begin
                phase = PH_LISTEN;
                r.drop_cause = CAUSE_HEARTBEAT;
              end
            end
            default: ;
          endcase
        end
        CMD_SLOT: begin
          if (phase == PH_RESPOND) begin
            r.send_kind = SEND_RECOGNIZE;
            r.tx_byte0 = recog_id;
            r.tx_byte1 = rx_id;
            r.tx_byte2 = paired;
            r.expect_reply = 1'b1;
          end else if (phase == PH_CONNECTED) begin
            led = ~led;
            r.send_kind = SEND_PAYLOAD;
            r.expect_reply = 1'b1;
          end
        end
        default: ;
      endcase
      case (phase)
        PH_RESPOND:   r.link_state = LS_RESPOND;
        PH_CONFIRM:   r.link_state = LS_CONFIRM;
        PH_CONNECTED: r.link_state = LS_CONNECTED;
        PH_OTHER:     r.link_state = LS_OTHER;
        default:      r.link_state = LS_LISTEN;
      endcase
      r.led_on = led;
      reports_due.push_back(r);
    endfunction

    function void check_report(out_t got);
      out_t want;
      if (reports_due.size() == 0) begin
        bad_reports++;
        if (bad_reports <= 10) $display("unexpected report: state %0d kind %0d cause %0d",
                                         got.link_state, got.send_kind, got.drop_cause);
        return;
      end
      want = reports_due.pop_front();
      if (got.link_state !== want.link_state || got.send_request !== want.send_request ||
          got.send_kind !== want.send_kind || got.tx_byte0 !== want.tx_byte0 ||
          got.tx_byte1 !== want.tx_byte1 || got.tx_byte2 !== want.tx_byte2 ||
          got.expect_reply !== want.expect_reply || got.led_on !== want.led_on ||
          got.drop_cause !== want.drop_cause) begin
        bad_reports++;
        if (bad_reports <= 10)
          $display({"report mismatch (expected/actual): state %0d/%0d req %0d/%0d ",
                    "kind %0d/%0d tx %h%h%h/%h%h%h exp %0d/%0d led %0d/%0d cause %0d/%0d"},
                   want.link_state, got.link_state, want.send_request, got.send_request,
                   want.send_kind, got.send_kind, want.tx_byte0, want.tx_byte1,
                   want.tx_byte2, got.tx_byte0, got.tx_byte1, got.tx_byte2,
                   want.expect_reply, got.expect_reply, want.led_on, got.led_on,
                   want.drop_cause, got.drop_cause);
      end
    endfunction

    function int pending();
      return reports_due.size();
    endfunction
  endclass

  link_tracker tracker;

  always #2 clk = ~clk;

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) tracker.check_report(out_data);
  end

  function automatic in_t mk(logic [1:0] c, logic [7:0] id, logic [7:0] b1, logic [7:0] b2,
                             logic w);
    in_t ev;
    ev.cmd = c;
    ev.msg_id = id;
    ev.msg_byte1 = b1;
    ev.msg_byte2 = b2;
    ev.reply_wanted = w;
    return ev;
  endfunction

  function automatic in_t rand_item();
    return mk(2'($urandom_range(3)), 8'($urandom), 8'($urandom), 8'($urandom),
              1'($urandom));
  endfunction

  // ticks, slots and messages mixed for pairing phases
  function automatic in_t busy_event();
    in_t ev;
    int r;
    ev = rand_item();
    r = $urandom_range(99);
    if (r < 45) ev.cmd = CMD_TICK;
    else if (r < 75) ev.cmd = CMD_SLOT;
    else if (r < 92) ev.cmd = CMD_MSG;
    else ev.cmd = CMD_UNUSED;
    return ev;
  endfunction

  function automatic in_t link_event();
    in_t ev;
    int r;
    ev = rand_item();
    r = $urandom_range(99);
    if (r < 50) begin
      ev.cmd = CMD_MSG;
      if ($urandom_range(1) == 1) ev.msg_id = 8'($urandom_range(63));
      // keep most messages from ending the link
      if (ev.msg_id == tracker.disc_id && $urandom_range(9) != 0) ev.msg_id = ev.msg_id ^ 8'h40;
    end else if (r < 78) ev.cmd = CMD_TICK;
    else if (r < 96) ev.cmd = CMD_SLOT;
    else ev.cmd = CMD_UNUSED;
    return ev;
  endfunction

  // a confirm in confirm wait always matches; the competing case is saved for the end
  function automatic in_t no_rival(in_t ev);
    in_t fixed;
    fixed = ev;
    if (tracker.phase == PH_CONFIRM && ev.cmd == CMD_MSG && ev.msg_id == tracker.confirm_id) begin
      fixed.msg_byte1 = tracker.paired;
      fixed.msg_byte2 = tracker.rx_id;
    end
    return fixed;
  endfunction

  task automatic send(input in_t ev);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = ev;
    do @(posedge clk); while (in_stall);
    tracker.take_event(ev);
    items_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_reg(idx, val);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic configure(input logic [7:0] rx, input logic [7:0] beacon,
                           input logic [7:0] confirm, input logic [7:0] recog,
                           input logic [7:0] disc, input logic [63:0] mask,
                           input logic [IDLE_W-1:0] abandon);
    wait_drained();
    write_reg(REG_OWN_ID, 64'(rx));
    write_reg(REG_BEACON_ID, 64'(beacon));
    write_reg(REG_CONFIRM_ID, 64'(confirm));
    write_reg(REG_RECOGNIZE_ID, 64'(recog));
    write_reg(REG_DISCONNECT_ID, 64'(disc));
    write_reg(REG_KEEPALIVE, mask);
    write_reg(REG_ABANDON, 64'(abandon));
  endtask

  task automatic send_noise();
    send(no_rival(rand_item()));
  endtask

  // from any phase but the terminal one: settle to listening, then pair up to confirm wait
  task automatic pair_up();
    while (tracker.phase != PH_LISTEN) begin
      if (tracker.phase == PH_CONNECTED) send(mk(CMD_MSG, tracker.disc_id, 8'h00, 8'h00, 1'b0));
      else send(mk(CMD_TICK, 8'h00, 8'h00, 8'h00, 1'b0));
    end
    send(mk(CMD_MSG, tracker.beacon_id, 8'($urandom), 8'($urandom), 1'b0));
    while (tracker.phase != PH_CONFIRM) send(mk(CMD_TICK, 8'h00, 8'h00, 8'h00, 1'b0));
  endtask

  task automatic run_session();
    int n;
    bit connect_ok;
    n = $urandom_range(3);
    repeat (n) send_noise();
    if (tracker.phase == PH_LISTEN)
      send(mk(CMD_MSG, tracker.beacon_id, 8'($urandom), 8'($urandom), 1'($urandom)));
    while (tracker.phase == PH_RESPOND) send(busy_event());
    connect_ok = ($urandom_range(99) < 80);
    while (tracker.phase == PH_CONFIRM) begin
      if (connect_ok && ($urandom_range(3) == 0 ||
                         tracker.attempts == ATTEMPT_W'(CONFIRM_LIMIT_DEF - 1)))
        send(mk(CMD_MSG, tracker.confirm_id, tracker.paired, tracker.rx_id, 1'($urandom)));
      else
        send(no_rival(busy_event()));
    end
    n = $urandom_range(2, 40);
    while (tracker.phase == PH_CONNECTED && n > 0) begin
      send(link_event());
      n--;
    end
    if (tracker.phase == PH_CONNECTED) begin
      if ($urandom_range(1) == 1 && tracker.abandon < 16'd64) begin
        while (tracker.phase == PH_CONNECTED) send(mk(CMD_TICK, 8'($urandom), 8'h00, 8'h00, 1'b1));
      end else begin
        send(mk(CMD_MSG, tracker.disc_id, 8'($urandom), 8'($urandom), 1'($urandom)));
      end
    end
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
    int start;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    start = items_sent;
    while (items_sent - start < count) begin
      if ($urandom_range(9) == 0) send_noise();
      else run_session();
      if ($urandom_range(49) == 0) wait_drained();
    end
  endtask

  initial begin
    #2_000_000;
    $display("radio_link_pairing_keepalive test failed");
    $finish;
  end

  initial begin
    tracker = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed pass on reset registers: every id is zero, abandon is ten
    send(mk(CMD_UNUSED, 8'hFF, 8'hFF, 8'hFF, 1'b1));
    send(mk(CMD_SLOT, 8'h00, 8'h00, 8'h00, 1'b0));
    send(mk(CMD_MSG, 8'h05, 8'h12, 8'h34, 1'b1));
    send(mk(CMD_TICK, 8'h00, 8'h00, 8'h00, 1'b0));
    send(mk(CMD_MSG, 8'h00, 8'hFF, 8'hAA, 1'b1));
    send(mk(CMD_MSG, 8'h00, 8'h00, 8'h00, 1'b1));
    send(mk(CMD_SLOT, 8'h00, 8'h00, 8'h00, 1'b0));
    send(mk(CMD_TICK, 8'h00, 8'h00, 8'h00, 1'b0));
    send(mk(CMD_SLOT, 8'hFF, 8'hFF, 8'hFF, 1'b1));
    send(mk(CMD_UNUSED, 8'h00, 8'h00, 8'h00, 1'b0));
    repeat (4) send(mk(CMD_TICK, 8'h00, 8'h00, 8'h00, 1'b0));
    send(mk(CMD_SLOT, 8'h00, 8'h00, 8'h00, 1'b0));
    send(mk(CMD_MSG, 8'h07, 8'hFF, 8'h00, 1'b1));
    send(mk(CMD_TICK, 8'h00, 8'h00, 8'h00, 1'b0));
    send(mk(CMD_MSG, 8'h00, 8'hFF, 8'h00, 1'b0));
    send(mk(CMD_MSG, 8'hC8, 8'h00, 8'h00, 1'b1));
    send(mk(CMD_MSG, 8'h3F, 8'h00, 8'h00, 1'b0));
    send(mk(CMD_SLOT, 8'h00, 8'h00, 8'h00, 1'b0));
    send(mk(CMD_TICK, 8'h00, 8'h00, 8'h00, 1'b0));
    send(mk(CMD_MSG, 8'h00, 8'h00, 8'h00, 1'b0));

    configure(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
              {$urandom, $urandom}, 16'd1);
    run_phase(0, 0, 300);

    configure(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, '1, 16'hFFFF);
    run_phase(78, 0, 300);

    configure(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, {$urandom, $urandom},
              16'($urandom_range(2, 30)));
    run_phase(0, 78, 300);

    configure(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
              8'($urandom_range(63)), '1, 16'($urandom_range(2, 300)));
    run_phase(38, 38, 300);

    // with abandon at its top a long idle run keeps the link up
    send_idle_pct = 0;
    recv_stall_pct = 0;
    wait_drained();
    write_reg(REG_ABANDON, 64'hFFFF);
    pair_up();
    send(mk(CMD_MSG, tracker.confirm_id, tracker.paired, tracker.rx_id, 1'b0));
    repeat (100) send(mk(CMD_TICK, 8'h00, 8'h00, 8'h00, 1'b0));

    // competing receiver, then the terminal phase ignores everything
    configure(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
              64'h0, 16'hFFFE);
    send_idle_pct = 38;
    recv_stall_pct = 38;
    pair_up();
    if ($urandom_range(1) == 1)
      send(mk(CMD_MSG, tracker.confirm_id, tracker.paired, tracker.rx_id ^ 8'h5A, 1'b1));
    else
      send(mk(CMD_MSG, tracker.confirm_id, tracker.paired ^ 8'h81, tracker.rx_id, 1'b0));
    repeat (40) send(rand_item());

    wait_drained();
    repeat (8) @(posedge clk);
    if (tracker.bad_reports == 0) begin
      $display("radio_link_pairing_keepalive test passed");
    end else begin
      $display("radio_link_pairing_keepalive test failed");
    end
    $finish;
  end

endmodule
